// ===== src/assert_macros.svh =====
// assertion helpers shared by the rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// a implies b on the same edge
`define ASSERT_IMPL(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (b)) \
        else $error("assertion failed");

// a implies b on the next edge
`define ASSERT_NEXT(label, clk, rst_n, a, b) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (b)) \
        else $error("assertion failed");

`endif

// ===== src/fct_pkg.sv =====
// ----------------------------------------------------------------------------
// fct_pkg
// types and constants of the frustum cull test block
// ----------------------------------------------------------------------------
package fct_pkg;

    localparam int PLANE_COUNT      = 6;
    localparam int NORMAL_FRAC_BITS = 14;
    localparam int PIDX_W           = 3;
    localparam int SUM_W            = 48;

    typedef enum logic [1:0] {
        FUNC_LOAD   = 2'd0,
        FUNC_BOX    = 2'd1,
        FUNC_SPHERE = 2'd2,
        FUNC_NONE   = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        VERDICT_INSIDE     = 2'd0,
        VERDICT_INTERSECTS = 2'd1,
        VERDICT_OUTSIDE    = 2'd2
    } verdict_t;

    typedef struct packed {
        logic [1:0]          func;
        logic [PIDX_W-1:0]   plane_index;
        logic signed [15:0]  normal_x;
        logic signed [15:0]  normal_y;
        logic signed [15:0]  normal_z;
        logic signed [31:0]  plane_offset;
        logic signed [31:0]  a_x;
        logic signed [31:0]  a_y;
        logic signed [31:0]  a_z;
        logic signed [31:0]  b_x;
        logic signed [31:0]  b_y;
        logic signed [31:0]  b_z;
    } req_t;

    typedef struct packed {
        logic [1:0] verdict;
    } rsp_t;

    // per-plane flags handed from the evaluation lanes to the verdict stage
    typedef struct packed {
        logic box_fail;
        logic below_neg_r;
        logic below_r;
    } plane_flags_t;

endpackage

// ===== src/fct_if.sv =====
// ----------------------------------------------------------------------------
// fct_if
// valid/ready channel carrying one payload
// ----------------------------------------------------------------------------
interface fct_if #(parameter type T = logic) ();
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== src/fct_plane_lane.sv =====
// ----------------------------------------------------------------------------
// fct_plane_lane
// evaluates one plane over three pipeline stages: products, shift and sum,
// compare
// ----------------------------------------------------------------------------
module fct_plane_lane
    import fct_pkg::*;
(
    input  logic               clk,
    input  logic               en,
    input  logic signed [15:0] nx,
    input  logic signed [15:0] ny,
    input  logic signed [15:0] nz,
    input  logic signed [31:0] d,
    input  logic signed [31:0] a_x,
    input  logic signed [31:0] a_y,
    input  logic signed [31:0] a_z,
    input  logic signed [31:0] b_x,
    input  logic signed [31:0] b_y,
    input  logic signed [31:0] b_z,
    output plane_flags_t       flags
);

    logic signed [47:0] pa_reg [3];
    logic signed [47:0] pb_reg [3];
    logic signed [31:0] d1_reg;
    logic signed [31:0] r1_reg;
    logic signed [SUM_W-1:0] box_reg;
    logic signed [SUM_W-1:0] dist_reg;
    logic signed [31:0] r2_reg;
    plane_flags_t flags_reg;

    logic signed [47:0] mx [3];
    logic signed [SUM_W-1:0] box_next;
    logic signed [SUM_W-1:0] dist_next;
    logic signed [32:0] neg_r;

    // stage 1: six products
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            pa_reg[0] <= 48'(a_x) * 48'(nx);
            pa_reg[1] <= 48'(a_y) * 48'(ny);
            pa_reg[2] <= 48'(a_z) * 48'(nz);
            pb_reg[0] <= 48'(b_x) * 48'(nx);
            pb_reg[1] <= 48'(b_y) * 48'(ny);
            pb_reg[2] <= 48'(b_z) * 48'(nz);
            d1_reg    <= d;
            r1_reg    <= b_x;
        end
    end

    // stage 2: floor shift and sums
    always_comb
    begin
        box_next  = SUM_W'(d1_reg);
        dist_next = SUM_W'(d1_reg);
        for (int k = 0; k < 3; k++)
        begin
            mx[k]     = (pa_reg[k] > pb_reg[k]) ? pa_reg[k] : pb_reg[k];
            box_next  = box_next + (mx[k] >>> NORMAL_FRAC_BITS);
            dist_next = dist_next + (pa_reg[k] >>> NORMAL_FRAC_BITS);
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            box_reg  <= box_next;
            dist_reg <= dist_next;
            r2_reg   <= r1_reg;
        end
    end

    // stage 3: compares
    assign neg_r = -33'(r2_reg);

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            flags_reg.box_fail    <= !(box_reg > 0);
            flags_reg.below_neg_r <= dist_reg < SUM_W'(neg_r);
            flags_reg.below_r     <= dist_reg < SUM_W'(r2_reg);
        end
    end

    assign flags = flags_reg;

endmodule

// ===== src/frustum_cull_test.sv =====
// ----------------------------------------------------------------------------
// frustum_cull_test
// box and sphere test against a table of six frustum planes
// ----------------------------------------------------------------------------
// requests arrive on req: func selects load plane, box test or sphere test.
// a load writes one plane of the table and gives no response; an unused func
// or a plane index past the table is dropped. each test gives one verdict on
// rsp. tests run through a five stage pipeline: products, shifted sums,
// plane compares, verdict merge and the output register. one request per
// cycle is taken when rsp is not stalled; the six plane lanes work in
// parallel. a load reaches the table in the cycle it is taken and is seen
// by the next request. when rsp stalls, the pipeline still advances while
// stage four is empty; req.ready falls only when the output register holds
// a stalled verdict and stage four holds another one.
// reset clears the plane table to zero and empties the pipeline.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module frustum_cull_test
    import fct_pkg::*;
(
    input  logic  clk,
    input  logic  rst_n,
    fct_if.sink   req,
    fct_if.source rsp
);

    localparam int DEPTH = 4;

    logic signed [15:0] nx_reg [PLANE_COUNT];
    logic signed [15:0] ny_reg [PLANE_COUNT];
    logic signed [15:0] nz_reg [PLANE_COUNT];
    logic signed [31:0] d_reg  [PLANE_COUNT];

    logic [DEPTH-1:0] vld_reg;
    logic [1:0]       fn_reg [DEPTH];
    logic             out_vld_reg;
    rsp_t             out_reg;

    plane_flags_t flags [PLANE_COUNT];
    logic         adv;
    logic         take;
    logic         test_in;
    logic         any_out;
    logic         all_in;
    logic         box_in;
    logic [1:0]   verdict_next;

    // pipeline moves when the output register can take what stage four holds
    assign adv       = !out_vld_reg || rsp.ready || !vld_reg[DEPTH-1];
    assign req.ready = adv;
    assign take      = req.valid && req.ready;
    assign test_in   = req.data.func == FUNC_BOX || req.data.func == FUNC_SPHERE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                nx_reg[p] <= '0;
                ny_reg[p] <= '0;
                nz_reg[p] <= '0;
                d_reg[p]  <= '0;
            end
        end
        else if (take && req.data.func == FUNC_LOAD
                 && req.data.plane_index < PIDX_W'(PLANE_COUNT))
        begin
            nx_reg[req.data.plane_index] <= req.data.normal_x;
            ny_reg[req.data.plane_index] <= req.data.normal_y;
            nz_reg[req.data.plane_index] <= req.data.normal_z;
            d_reg[req.data.plane_index]  <= req.data.plane_offset;
        end
    end

    for (genvar p = 0; p < PLANE_COUNT; p++)
    begin : g_lane
        fct_plane_lane u_lane (
            .clk   (clk),
            .en    (adv),
            .nx    (nx_reg[p]),
            .ny    (ny_reg[p]),
            .nz    (nz_reg[p]),
            .d     (d_reg[p]),
            .a_x   (req.data.a_x),
            .a_y   (req.data.a_y),
            .a_z   (req.data.a_z),
            .b_x   (req.data.b_x),
            .b_y   (req.data.b_y),
            .b_z   (req.data.b_z),
            .flags (flags[p])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[DEPTH-2:0], take && test_in};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            fn_reg[0] <= req.data.func;
            for (int s = 1; s < DEPTH; s++)
            begin
                fn_reg[s] <= fn_reg[s-1];
            end
        end
    end

    // stage 4: merge plane flags (flags are valid at stage index 2)
    logic [1:0] merged_reg;

    always_comb
    begin
        any_out = 1'b0;
        all_in  = 1'b1;
        box_in  = 1'b1;
        for (int p = 0; p < PLANE_COUNT; p++)
        begin
            if (flags[p].box_fail)
                box_in = 1'b0;
            if (flags[p].below_neg_r)
                any_out = 1'b1;
            else if (flags[p].below_r)
                all_in = 1'b0;
        end
        if (fn_reg[2] == FUNC_BOX)
            verdict_next = box_in ? VERDICT_INSIDE : VERDICT_OUTSIDE;
        else if (any_out)
            verdict_next = VERDICT_OUTSIDE;
        else
            verdict_next = all_in ? VERDICT_INSIDE : VERDICT_INTERSECTS;
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            merged_reg <= verdict_next;
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_vld_reg <= 1'b0;
        end
        else if (adv && vld_reg[DEPTH-1])
        begin
            out_vld_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_vld_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv && vld_reg[DEPTH-1])
            out_reg.verdict <= merged_reg;
    end

    assign rsp.valid = out_vld_reg;
    assign rsp.data  = out_reg;

    `ASSERT_IMPL(a_stall_holds, clk, rst_n, !req.ready, out_vld_reg && vld_reg[DEPTH-1])
    `ASSERT_IMPL(a_verdict_code, clk, rst_n, rsp.valid, rsp.data.verdict != 2'd3)
    `ASSERT_NEXT(a_stalled_out_stays, clk, rst_n, rsp.valid && !rsp.ready, rsp.valid)

endmodule

// ===== tb/sv/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the frustum cull test block
// ----------------------------------------------------------------------------
// loads random and boundary planes and runs box and sphere tests through
// the block under several idle and stall mixes. a fixed-point predictor
// keeps its own plane table and queues expected verdicts; a scoreboard
// compares every response in order.
// ----------------------------------------------------------------------------
module tb;
    import fct_pkg::*;

    class cull_scoreboard;
        logic signed [15:0] nrm [PLANE_COUNT][3];
        logic signed [31:0] ofs [PLANE_COUNT];
        verdict_t pending [$];
        int mismatches;

        function new();
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                ofs[p] = 0;
                for (int k = 0; k < 3; k++)
                    nrm[p][k] = 0;
            end
            mismatches = 0;
        endfunction

        function void note_request(req_t r);
            logic signed [47:0] lo [3];
            logic signed [47:0] hi [3];
            logic signed [47:0] sum, m0, m1, rad;
            logic in_all, outside, all_in;
            if (r.func == FUNC_LOAD)
            begin
                if (r.plane_index < PLANE_COUNT)
                begin
                    nrm[r.plane_index][0] = r.normal_x;
                    nrm[r.plane_index][1] = r.normal_y;
                    nrm[r.plane_index][2] = r.normal_z;
                    ofs[r.plane_index] = r.plane_offset;
                end
                return;
            end
            if (r.func == FUNC_NONE)
                return;
            lo[0] = r.a_x; lo[1] = r.a_y; lo[2] = r.a_z;
            hi[0] = r.b_x; hi[1] = r.b_y; hi[2] = r.b_z;
            rad = r.b_x;
            in_all = 1; outside = 0; all_in = 1;
            for (int p = 0; p < PLANE_COUNT; p++)
            begin
                sum = 48'(ofs[p]);
                for (int k = 0; k < 3; k++)
                begin
                    m0 = lo[k] * 48'(nrm[p][k]);
                    m1 = hi[k] * 48'(nrm[p][k]);
                    if (r.func == FUNC_BOX)
                        sum += ((m0 > m1) ? m0 : m1) >>> NORMAL_FRAC_BITS;
                    else
                        sum += m0 >>> NORMAL_FRAC_BITS;
                end
                if (!(sum > 0))
                    in_all = 0;
                if (sum < -rad)
                    outside = 1;
                else if (sum < rad)
                    all_in = 0;
            end
            if (r.func == FUNC_BOX)
                pending.insert(pending.size(), in_all ? VERDICT_INSIDE : VERDICT_OUTSIDE);
            else
                pending.insert(pending.size(), outside ? VERDICT_OUTSIDE :
                    (all_in ? VERDICT_INSIDE : VERDICT_INTERSECTS));
        endfunction

        function void check_verdict(rsp_t s);
            verdict_t want;
            if (pending.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected verdict %0d", s.verdict);
                return;
            end
            want = pending.pop_front();
            if (s.verdict !== want)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("verdict mismatch: expected %0d actual %0d", want, s.verdict);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    fct_if #(.T(req_t)) req ();
    fct_if #(.T(rsp_t)) rsp ();

    frustum_cull_test dut (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (req.sink),
        .rsp  (rsp.source)
    );

    cull_scoreboard sb;
    int idle_pct;
    int stall_pct;
    int hold_off;
    longint cycles;

    initial
    begin
        clk = 0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 2000000)
        begin
            $display("TB_ERROR");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && rsp.valid && rsp.ready)
            sb.check_verdict(rsp.data);
        if (hold_off > 0)
        begin
            hold_off <= hold_off - 1;
            rsp.ready <= 0;
        end
        else
            rsp.ready <= ($urandom_range(99) >= stall_pct);
    end

    function automatic logic [31:0] rand_coord();
        case ($urandom_range(5))
            0: return 32'h8000_0000;
            1: return 32'h7fff_ffff;
            2: return $urandom;
            default: return 32'(signed'($urandom_range(20000)) - 10000);
        endcase
    endfunction

    function automatic req_t rand_load();
        req_t r;
        r = '0;
        r.func = FUNC_LOAD;
        r.plane_index = ($urandom_range(15) == 0) ? 3'($urandom_range(7, 6))
                                                   : 3'($urandom_range(5));
        r.normal_x = $urandom;
        r.normal_y = $urandom;
        r.normal_z = $urandom;
        if ($urandom_range(1))
        begin
            r.normal_x = 16'(signed'($urandom_range(32768)) - 16384);
            r.normal_y = 16'(signed'($urandom_range(32768)) - 16384);
            r.normal_z = 16'(signed'($urandom_range(32768)) - 16384);
        end
        r.plane_offset = rand_coord();
        r.a_x = $urandom; r.b_z = $urandom;
        return r;
    endfunction

    function automatic req_t rand_test();
        req_t r;
        r = '0;
        r.func = $urandom_range(1) ? FUNC_BOX : FUNC_SPHERE;
        r.plane_index = $urandom;
        r.normal_x = $urandom; r.normal_y = $urandom; r.normal_z = $urandom;
        r.plane_offset = $urandom;
        r.a_x = rand_coord(); r.a_y = rand_coord(); r.a_z = rand_coord();
        r.b_x = rand_coord(); r.b_y = rand_coord(); r.b_z = rand_coord();
        if (r.func == FUNC_SPHERE && $urandom_range(3) != 0)
            r.b_x = $urandom_range(40000);
        return r;
    endfunction

    task automatic send(req_t r);
        req.data <= r;
        req.valid <= 1;
        @(posedge clk);
        while (!req.ready)
            @(posedge clk);
        sb.note_request(r);
        if ($urandom_range(99) < idle_pct)
        begin
            req.valid <= 0;
            @(posedge clk);
            while ($urandom_range(99) < idle_pct)
                @(posedge clk);
        end
    endtask

    task automatic run_phase(int n, int idle, int stall);
        idle_pct = idle;
        stall_pct = stall;
        for (int i = 0; i < n; i++)
        begin
            if ($urandom_range(9) < 2)
                send(rand_load());
            else if ($urandom_range(49) == 0)
            begin
                req_t r;
                r = rand_test();
                r.func = FUNC_NONE;
                send(r);
            end
            else
                send(rand_test());
        end
    endtask

    initial
    begin
        req_t r;
        sb = new();
        cycles = 0;
        hold_off = 0;
        idle_pct = 0;
        stall_pct = 0;
        rst_n = 0;
        req.valid = 0;
        req.data = '0;
        rsp.ready = 0;
        repeat (10) @(posedge clk);
        rst_n <= 1;
        @(posedge clk);

        // reset table: box outside, sphere by radius sign
        r = '0; r.func = FUNC_BOX; send(r);
        r = '0; r.func = FUNC_SPHERE; r.b_x = 5; send(r);
        r = '0; r.func = FUNC_SPHERE; r.b_x = -5; send(r);
        r = '0; r.func = FUNC_SPHERE; send(r);
        r = '1; r.func = FUNC_NONE; send(r);
        // extreme planes
        for (int p = 0; p < 8; p++)
        begin
            r = '0; r.func = FUNC_LOAD; r.plane_index = 3'(p);
            r.normal_x = (p % 2) ? 16'h8000 : 16'h7fff;
            r.normal_y = (p % 3) ? 16'h7fff : 16'h8000;
            r.normal_z = 16'hffff;
            r.plane_offset = (p % 2) ? 32'h7fff_ffff : 32'h8000_0000;
            send(r);
        end
        r = '0; r.func = FUNC_BOX;
        r.a_x = 32'h8000_0000; r.a_y = 32'h8000_0000; r.a_z = 32'h8000_0000;
        r.b_x = 32'h7fff_ffff; r.b_y = 32'h7fff_ffff; r.b_z = 32'h7fff_ffff;
        send(r);
        r.func = FUNC_SPHERE; send(r);
        r.a_x = 32'h7fff_ffff; r.b_x = 32'h8000_0000; send(r);
        r.func = FUNC_BOX; send(r);
        r = '1; r.func = FUNC_SPHERE; send(r);
        r.func = FUNC_BOX; send(r);

        run_phase(400, 0, 0);
        run_phase(300, 85, 0);
        run_phase(300, 0, 85);
        run_phase(300, 21, 21);
        hold_off <= 300;
        run_phase(100, 0, 0);
        req.valid <= 0;

        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
        if (sb.mismatches == 0 && sb.pending.size() == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end
endmodule

// ===== filelist.f =====
+incdir+src
src/fct_pkg.sv
src/fct_if.sv
src/fct_plane_lane.sv
src/frustum_cull_test.sv
tb/sv/tb.sv
